FILE: hdl/mlr_pkg.sv
// Shared types and constants for the merged likelihood ratio block.
`timescale 1ns / 1ps

package mlr_pkg;

  // Widths of the payload fields.
  localparam int FIELD_W = 32;
  localparam int CLASS_W = 7;

  // An exact sum of two likelihoods needs one bit more than a likelihood.
  localparam int MRG_W = FIELD_W + 1;

  // The three-operand ratio difference stays exact at this width.
  localparam int RATIO_CALC_W = MRG_W + 3;

  // Saturation compares are done at this width.
  localparam int SAT_CMP_W = 64;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;

  typedef logic signed [FIELD_W-1:0] lik_t;
  typedef logic [CLASS_W-1:0] class_t;
  typedef logic signed [MRG_W-1:0] mrg_t;

  // One classified element as it travels from the front to the back.
  typedef struct packed {
    mrg_t   merged;
    lik_t   field_lik;
    lik_t   cell_loglik;
    class_t field_class;
    class_t cell_class;
    class_t cls;
    logic   first;
    logic   last;
    logic   bad;
    logic   hit_field;
    logic   hit_cell;
  } item_t;

endpackage

FILE: hdl/mlr_front.sv
// Front end: accepts elements, counts positions, forms the saturated merged sum and classifies each element.
`timescale 1ns / 1ps

module mlr_front #(
  parameter int LIK_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  mlr_pkg::class_t n_classes,
  input  logic           in_valid,
  output logic           in_stall,
  input  mlr_pkg::lik_t  field_lik,
  input  mlr_pkg::lik_t  cell_loglik,
  input  mlr_pkg::class_t field_class,
  input  mlr_pkg::class_t cell_class,
  output logic           push,
  output mlr_pkg::item_t push_item,
  input  logic           queue_full
);
  import mlr_pkg::*;

  localparam logic signed [SAT_CMP_W-1:0] SAT_HI =
    (SAT_CMP_W'(1) <<< (LIK_WIDTH - 1)) - SAT_CMP_W'(1);
  localparam logic signed [SAT_CMP_W-1:0] SAT_LO = -SAT_HI - SAT_CMP_W'(1);

  class_t element_count;
  class_t element_count_next;

  logic [CLASS_W:0]             cls_wide;
  logic                         is_last;
  mrg_t                         sum;
  logic signed [SAT_CMP_W-1:0]  sum_ext;
  mrg_t                         merged;
  logic                         bad;

  // A transfer happens whenever an element is offered and the queue has room.
  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  // Position of this element within the vector, one-based.
  assign cls_wide = {1'b0, element_count} + (CLASS_W + 1)'(1);
  assign is_last  = cls_wide >= {1'b0, n_classes};

  // Exact sum, then saturation to the likelihood width.
  assign sum     = mrg_t'(field_lik) + mrg_t'(cell_loglik);
  assign sum_ext = SAT_CMP_W'(sum);
  always_comb begin
    if (sum_ext > SAT_HI) begin
      merged = MRG_W'(SAT_HI);
    end else if (sum_ext < SAT_LO) begin
      merged = MRG_W'(SAT_LO);
    end else begin
      merged = sum;
    end
  end

  // A class number of zero or beyond the vector length is flagged.
  assign bad = (field_class == '0) || (field_class > n_classes) ||
               (cell_class == '0) || (cell_class > n_classes);

  // Classified element handed to the queue.
  always_comb begin
    push_item.merged      = merged;
    push_item.field_lik   = field_lik;
    push_item.cell_loglik = cell_loglik;
    push_item.field_class = field_class;
    push_item.cell_class  = cell_class;
    push_item.cls         = cls_wide[CLASS_W-1:0];
    push_item.first       = (element_count == '0);
    push_item.last        = is_last;
    push_item.bad         = bad;
    push_item.hit_field   = (cls_wide == {1'b0, field_class});
    push_item.hit_cell    = (cls_wide == {1'b0, cell_class});
  end

  // Element counter wraps after the last element of a vector.
  always_comb begin
    element_count_next = element_count;
    if (push) begin
      element_count_next = is_last ? '0 : cls_wide[CLASS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      element_count <= '0;
    end else begin
      element_count <= element_count_next;
    end
  end

endmodule

FILE: hdl/mlr_queue.sv
// Short queue of classified elements between the front and the back.
`timescale 1ns / 1ps

module mlr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  mlr_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output mlr_pkg::item_t pop_item,
  output logic           not_empty
);
  import mlr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;

  assign full      = (fill == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign pop_item  = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

FILE: hdl/mlr_back.sv
// Back end: running maximum, class captures, ratio and the output register.
`timescale 1ns / 1ps

module mlr_back #(
  parameter int LIK_WIDTH = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            queue_valid,
  input  mlr_pkg::item_t  queue_item,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output mlr_pkg::lik_t   merged_lik,
  output mlr_pkg::class_t best_class,
  output mlr_pkg::lik_t   ratio,
  output logic            last,
  output logic            class_error
);
  import mlr_pkg::*;

  localparam logic signed [SAT_CMP_W-1:0] SAT_HI =
    (SAT_CMP_W'(1) <<< (LIK_WIDTH - 1)) - SAT_CMP_W'(1);
  localparam logic signed [SAT_CMP_W-1:0] SAT_LO = -SAT_HI - SAT_CMP_W'(1);

  typedef logic signed [RATIO_CALC_W-1:0] calc_t;

  // Stage one: element just applied to the running state.
  logic   s1_valid;
  item_t  s1_item;

  // Running state of the current vector.
  mrg_t   running_max;
  class_t max_class;
  lik_t   cell_at_field_class;
  lik_t   cell_at_cell_class;
  lik_t   field_at_field_class;
  lik_t   field_at_cell_class;

  logic   s2_load;
  logic   s1_ready;

  calc_t                        op_a;
  calc_t                        op_b;
  calc_t                        op_c;
  calc_t                        diff;
  logic signed [SAT_CMP_W-1:0]  diff_ext;
  lik_t                         ratio_sat;
  class_t                       best_sel;
  lik_t                         ratio_sel;

  // Pipeline flow: the output register loads when empty or being drained.
  assign s2_load  = s1_valid && (!out_valid || !out_stall);
  assign s1_ready = !s1_valid || s2_load;
  assign pop      = queue_valid && s1_ready;

  // Stage one control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= queue_valid;
    end
  end

  // Stage one payload and the running state, updated on each pop.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_max          <= '0;
      max_class            <= CLASS_W'(1);
      cell_at_field_class  <= '0;
      cell_at_cell_class   <= '0;
      field_at_field_class <= '0;
      field_at_cell_class  <= '0;
    end else if (pop) begin
      if (queue_item.first) begin
        running_max <= queue_item.merged;
        max_class   <= CLASS_W'(1);
      end else if (queue_item.merged > running_max) begin
        running_max <= queue_item.merged;
        max_class   <= queue_item.cls;
      end
      // A capture at a class position takes precedence over the vector clear.
      if (queue_item.hit_field) begin
        cell_at_field_class  <= queue_item.cell_loglik;
        field_at_field_class <= queue_item.field_lik;
      end else if (queue_item.first) begin
        cell_at_field_class  <= '0;
        field_at_field_class <= '0;
      end
      if (queue_item.hit_cell) begin
        cell_at_cell_class  <= queue_item.cell_loglik;
        field_at_cell_class <= queue_item.field_lik;
      end else if (queue_item.first) begin
        cell_at_cell_class  <= '0;
        field_at_cell_class <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_item <= queue_item;
    end
  end

  // Ratio operands depend on where the maximum lies.
  always_comb begin
    if (max_class == s1_item.field_class) begin
      op_a = calc_t'(cell_at_field_class);
      op_b = calc_t'(cell_at_cell_class);
      op_c = '0;
    end else if (max_class == s1_item.cell_class) begin
      op_a = calc_t'(field_at_cell_class);
      op_b = calc_t'(field_at_field_class);
      op_c = '0;
    end else begin
      op_a = calc_t'(running_max);
      op_b = calc_t'(cell_at_cell_class);
      op_c = calc_t'(field_at_field_class);
    end
  end

  // Exact difference, then saturation to the likelihood width.
  assign diff     = op_a - op_b - op_c;
  assign diff_ext = SAT_CMP_W'(diff);
  always_comb begin
    if (diff_ext > SAT_HI) begin
      ratio_sat = FIELD_W'(SAT_HI);
    end else if (diff_ext < SAT_LO) begin
      ratio_sat = FIELD_W'(SAT_LO);
    end else begin
      ratio_sat = FIELD_W'(diff);
    end
  end

  // Decision on the last element; other elements report zero.
  always_comb begin
    best_sel  = '0;
    ratio_sel = '0;
    if (s1_item.last) begin
      if (s1_item.bad) begin
        best_sel = max_class;
      end else if (s1_item.field_class == s1_item.cell_class) begin
        best_sel = s1_item.field_class;
      end else begin
        best_sel  = max_class;
        ratio_sel = ratio_sat;
      end
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s2_load) begin
      merged_lik  <= FIELD_W'(s1_item.merged);
      best_class  <= best_sel;
      ratio       <= ratio_sel;
      last        <= s1_item.last;
      class_error <= s1_item.bad;
    end
  end

  // A result that does not close a vector carries no decision.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> (best_class == '0) && (ratio == '0))
    else $error("decision fields set on a result that is not last");

  // A flagged last result never reports a ratio.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && last && class_error |-> (ratio == '0))
    else $error("ratio reported with a class error");

  // An element held in stage one is not lost while the output is blocked.
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_load |=> s1_valid)
    else $error("stage one element dropped");

  // The queue is only read while the element in stage one can move on.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> s1_ready && queue_valid)
    else $error("queue read while stage one is blocked");

endmodule

FILE: hdl/merged_likelihood_ratio.sv
// Top level of the merged likelihood ratio block.
`timescale 1ns / 1ps

// Merges a field and a cell log-likelihood vector (signed Q16.16) element by
// element and forms the log likelihood ratio of the merge. Elements arrive in
// class order; every transfer in gives one transfer out with the saturated
// sum, and the result of the final class element also carries the best class
// and the ratio. The block takes one element per clock cycle while the queue
// has room, set by the compare of each merged sum against the running maximum
// in the back end. From an input transfer to its result an element passes the
// front-to-back queue, the running-state update and the ratio and output
// register. A two-entry queue between front and back and the output register
// let input keep flowing while a result waits. num_classes is to be written by
// the user through cfg_write and cfg_data while idle; the block does not enforce
// this. Zero acts as one and values above MAX_CLASSES are clamped.
module merged_likelihood_ratio #(
  parameter int MAX_CLASSES = 64,
  parameter int LIK_WIDTH   = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  mlr_pkg::class_t cfg_data,
  input  logic            in_valid,
  output logic            in_stall,
  input  mlr_pkg::lik_t   field_lik,
  input  mlr_pkg::lik_t   cell_loglik,
  input  mlr_pkg::class_t field_class,
  input  mlr_pkg::class_t cell_class,
  output logic            out_valid,
  input  logic            out_stall,
  output mlr_pkg::lik_t   merged_lik,
  output mlr_pkg::class_t best_class,
  output mlr_pkg::lik_t   ratio,
  output logic            last,
  output logic            class_error
);
  import mlr_pkg::*;

  localparam int CLASS_MAX_CODE = (1 << CLASS_W) - 1;
  localparam class_t CLASS_CAP =
    CLASS_W'((MAX_CLASSES > CLASS_MAX_CODE) ? CLASS_MAX_CODE : MAX_CLASSES);

  class_t num_classes;
  class_t n_classes;

  logic   push;
  item_t  push_item;
  logic   queue_full;
  logic   pop;
  item_t  pop_item;
  logic   queue_valid;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_classes <= CLASS_W'(1);
    end else if (cfg_write) begin
      num_classes <= cfg_data;
    end
  end

  // Effective vector length.
  always_comb begin
    if (num_classes == '0) begin
      n_classes = CLASS_W'(1);
    end else if (num_classes > CLASS_CAP) begin
      n_classes = CLASS_CAP;
    end else begin
      n_classes = num_classes;
    end
  end

  mlr_front #(
    .LIK_WIDTH (LIK_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .n_classes   (n_classes),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .field_lik   (field_lik),
    .cell_loglik (cell_loglik),
    .field_class (field_class),
    .cell_class  (cell_class),
    .push        (push),
    .push_item   (push_item),
    .queue_full  (queue_full)
  );

  mlr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .not_empty (queue_valid)
  );

  mlr_back #(
    .LIK_WIDTH (LIK_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_valid (queue_valid),
    .queue_item  (pop_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .merged_lik  (merged_lik),
    .best_class  (best_class),
    .ratio       (ratio),
    .last        (last),
    .class_error (class_error)
  );

endmodule

FILE: sim/merged_likelihood_ratio_tb.sv
// Self-checking testbench for the merged likelihood ratio block.
`timescale 1ns / 1ps

module merged_likelihood_ratio_tb;
  import mlr_pkg::*;

  localparam int MAX_CLASS_COUNT = 64;
  localparam int HOLD_CYCLES = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;
  localparam lik_t LIK_MAX = 32'sh7FFF_FFFF;
  localparam lik_t LIK_MIN = 32'sh8000_0000;

  // One expected result transfer.
  typedef struct {
    lik_t   merged;
    class_t best;
    lik_t   ratio;
    logic   last_flag;
    logic   error_flag;
  } mlr_result_t;

  // Tracks the running maximum and captured likelihoods, and holds the
  // results still to come out of the block.
  class lik_ratio_scoreboard;
    mlr_result_t expected_q[$];
    int errors;
    bit [6:0] class_cfg;
    int unsigned elem_idx;
    longint run_max;
    int unsigned max_cls;
    longint cell_at_fc;
    longint cell_at_cc;
    longint field_at_fc;
    longint field_at_cc;

    function new();
      errors = 0;
      class_cfg = 1;
      elem_idx = 0;
      run_max = 0;
      max_cls = 1;
      cell_at_fc = 0;
      cell_at_cc = 0;
      field_at_fc = 0;
      field_at_cc = 0;
    endfunction

    function longint clamp_lik(longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
    endfunction

    function void write_classes(bit [6:0] v);
      class_cfg = v;
    endfunction

    function int outstanding();
      return expected_q.size();
    endfunction

    // Predicts the result of one accepted input transfer.
    function void note_element(lik_t f, lik_t c, class_t fcl, class_t ccl);
      int unsigned n;
      int unsigned position;
      bit bad;
      longint fv;
      longint cv;
      longint mrg;
      longint rat;
      mlr_result_t r;
      n = (class_cfg == 0) ? 1 :
          ((class_cfg > MAX_CLASS_COUNT) ? MAX_CLASS_COUNT : class_cfg);
      bad = (fcl == 0) || (fcl > n) || (ccl == 0) || (ccl > n);
      fv = longint'(f);
      cv = longint'(c);
      mrg = clamp_lik(fv + cv);
      position = elem_idx + 1;
      rat = 0;

      // The first element of a vector restarts the search and the captures.
      if (elem_idx == 0) begin
        run_max = mrg;
        max_cls = 1;
        cell_at_fc = 0;
        cell_at_cc = 0;
        field_at_fc = 0;
        field_at_cc = 0;
      end else if (mrg > run_max) begin
        run_max = mrg;
        max_cls = position;
      end
      if (position == fcl) begin
        cell_at_fc = cv;
        field_at_fc = fv;
      end
      if (position == ccl) begin
        cell_at_cc = cv;
        field_at_cc = fv;
      end

      r.merged = mrg[31:0];
      r.best = '0;
      r.last_flag = 1'b0;
      r.error_flag = bad;

      // The decision is made with the class numbers of the final element.
      if (position >= n) begin
        r.last_flag = 1'b1;
        if (bad) begin
          r.best = class_t'(max_cls);
        end else if (fcl == ccl) begin
          r.best = fcl;
        end else begin
          r.best = class_t'(max_cls);
          if (max_cls == fcl) begin
            rat = clamp_lik(cell_at_fc - cell_at_cc);
          end else if (max_cls == ccl) begin
            rat = clamp_lik(field_at_cc - field_at_fc);
          end else begin
            rat = clamp_lik(run_max - cell_at_cc - field_at_fc);
          end
        end
        elem_idx = 0;
      end else begin
        elem_idx++;
      end
      r.ratio = rat[31:0];
      expected_q.push_back(r);
    endfunction

    // Compares one result transfer with the oldest expectation.
    function void check_result(lik_t m, class_t b, lik_t rt, logic l, logic e);
      mlr_result_t want;
      bit wrong;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, merged_lik %0d last %b", $time, m, l);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      wrong = 1'b0;
      if (m !== want.merged) begin
        $display("%0t: merged_lik expected %0d got %0d", $time, want.merged, m);
        wrong = 1'b1;
      end
      if (b !== want.best) begin
        $display("%0t: best_class expected %0d got %0d", $time, want.best, b);
        wrong = 1'b1;
      end
      if (rt !== want.ratio) begin
        $display("%0t: ratio expected %0d got %0d", $time, want.ratio, rt);
        wrong = 1'b1;
      end
      if (l !== want.last_flag) begin
        $display("%0t: last expected %b got %b", $time, want.last_flag, l);
        wrong = 1'b1;
      end
      if (e !== want.error_flag) begin
        $display("%0t: class_error expected %b got %b", $time, want.error_flag, e);
        wrong = 1'b1;
      end
      if (wrong) errors++;
    endfunction
  endclass

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   cfg_write = 1'b0;
  class_t cfg_data = 7'd1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  lik_t   field_lik = '0;
  lik_t   cell_loglik = '0;
  class_t field_class = 7'd1;
  class_t cell_class = 7'd1;
  logic   out_valid;
  logic   out_stall = 1'b0;
  lik_t   merged_lik;
  class_t best_class;
  lik_t   ratio;
  logic   last;
  logic   class_error;

  lik_ratio_scoreboard sb;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  bit hold_req = 1'b0;
  int stall_left = 0;
  int idle_cycles = 0;
  bit [6:0] phase_cfg [8] = '{7'd0, 7'd1, 7'd2, 7'd3, 7'd7, 7'd64, 7'd127, 7'd5};
  int phase_len [8] = '{60, 60, 150, 150, 200, 200, 130, 200};

  merged_likelihood_ratio DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .field_lik(field_lik),
    .cell_loglik(cell_loglik),
    .field_class(field_class),
    .cell_class(cell_class),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .merged_lik(merged_lik),
    .best_class(best_class),
    .ratio(ratio),
    .last(last),
    .class_error(class_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short idle stretches with an occasional long one.
  function int idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function lik_t pick_lik();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return LIK_MAX;
          1: return LIK_MIN;
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2: return $urandom;
      3: return $urandom_range(0, 8) - 4;
      default: return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
    endcase
  endfunction

  // Mostly legal class numbers, with zero and out-of-range ones mixed in.
  function class_t pick_class(int unsigned n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 88) return class_t'($urandom_range(1, n));
    if (r < 92) return '0;
    if (r < 96) return class_t'($urandom_range(n + 1, 127));
    return class_t'($urandom_range(0, 127));
  endfunction

  // Offers one element, after an optional gap, and waits for its transfer.
  task send_element(lik_t f, lik_t c, class_t fcl, class_t ccl);
    int gap;
    gap = (gaps_on && $urandom_range(0, 99) < 30) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    field_lik <= f;
    cell_loglik <= c;
    field_class <= fcl;
    cell_class <= ccl;
    do @(posedge clk); while (in_stall);
    sb.note_element(f, c, fcl, ccl);
  endtask

  // Drains the block, then writes the class count register.
  task write_class_count(bit [6:0] v);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_classes(v);
  endtask

  // Random vectors: classes are picked anew at each vector start and now
  // and then in the middle of one.
  task send_random(int count, bit [6:0] cfg);
    int unsigned n;
    class_t fcl;
    class_t ccl;
    n = (cfg == 0) ? 1 : ((cfg > MAX_CLASS_COUNT) ? MAX_CLASS_COUNT : cfg);
    fcl = pick_class(n);
    ccl = pick_class(n);
    for (int i = 0; i < count; i++) begin
      if (sb.elem_idx == 0 || $urandom_range(0, 19) == 0) begin
        fcl = pick_class(n);
        ccl = ($urandom_range(0, 3) == 0) ? fcl : pick_class(n);
      end
      send_element(pick_lik(), pick_lik(), fcl, ccl);
    end
  endtask

  // Result side: checks every transfer and stalls at random.
  initial begin
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        sb.check_result(merged_lik, best_class, ratio, last, class_error);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else if (stalls_on && $urandom_range(0, 99) < 30) begin
        stall_left = idle_length() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Ends the run when no transfer happens on either side for too long.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAIL merged_likelihood_ratio");
    $finish;
  end

  initial begin
    bit [6:0] cfg;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset class count of one: saturation both ways and bad class numbers.
    send_element(LIK_MAX, LIK_MAX, 7'd1, 7'd1);
    send_element(LIK_MIN, LIK_MIN, 7'd1, 7'd2);
    send_element(LIK_MAX, LIK_MIN, 7'd0, 7'd1);

    write_class_count(7'd4);
    // Maximum at the field class with a tie after it; the ratio saturates low.
    send_element(LIK_MIN, LIK_MIN, 7'd2, 7'd3);
    send_element(LIK_MAX, LIK_MIN, 7'd2, 7'd3);
    send_element(LIK_MIN, LIK_MAX, 7'd2, 7'd3);
    send_element(LIK_MIN, LIK_MIN, 7'd2, 7'd3);
    // Maximum at the cell class; the ratio saturates high.
    send_element(LIK_MIN, 32'sd0, 7'd1, 7'd4);
    send_element(32'sd0, 32'sd0, 7'd1, 7'd4);
    send_element(32'sd0, 32'sd0, 7'd1, 7'd4);
    send_element(LIK_MAX, 32'sd0, 7'd1, 7'd4);
    // Maximum at neither class.
    send_element(-32'sd100, 32'sd10, 7'd1, 7'd2);
    send_element(32'sd3, -32'sd200, 7'd1, 7'd2);
    send_element(32'sd1000, 32'sd1000, 7'd1, 7'd2);
    send_element(32'sd0, 32'sd0, 7'd1, 7'd2);
    // Field class equal to cell class.
    send_element(32'sd7, -32'sd9, 7'd3, 7'd3);
    send_element(32'sd70000, 32'sd5, 7'd3, 7'd3);
    send_element(-32'sd1, 32'sd12, 7'd3, 7'd3);
    send_element(32'sd123456, -32'sd654321, 7'd3, 7'd3);
    // Class numbers change inside the vector and the field class is out of range at the end.
    send_element(32'sd50, 32'sd50, 7'd2, 7'd0);
    send_element(32'sd80, 32'sd10, 7'd127, 7'd3);
    send_element(-32'sd5, 32'sd20, 7'd2, 7'd3);
    send_element(32'sd90, 32'sd1, 7'd5, 7'd3);

    // Fixed register settings, extremes among them; some end mid-vector.
    for (int p = 0; p < 8; p++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      write_class_count(phase_cfg[p]);
      if (p == 3) begin
        // Long receiver hold-off while the sender keeps offering.
        gaps_on = 1'b0;
        hold_req = 1'b1;
      end
      send_random(phase_len[p], phase_cfg[p]);
    end

    // Random register settings, mostly small class counts.
    for (int p = 0; p < 8; p++) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      cfg = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127)) :
                                          7'($urandom_range(1, 12));
      write_class_count(cfg);
      send_random(100, cfg);
    end

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("PASS merged_likelihood_ratio");
    end else begin
      $display("FAIL merged_likelihood_ratio");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/mlr_pkg.sv
hdl/mlr_front.sv
hdl/mlr_queue.sv
hdl/mlr_back.sv
hdl/merged_likelihood_ratio.sv
sim/merged_likelihood_ratio_tb.sv
